### rtl/core/swq_pkg.sv
// Shared types and constants for the segmented word queue.
`default_nettype none
package swq_pkg;

   localparam int TYPE_W     = 2;
   localparam int DATA_W     = 32;
   localparam int LEN_W      = 7;
   localparam int STAT_W     = 2;
   localparam int MAXSEG_W   = 9;
   localparam logic [MAXSEG_W-1:0] MAXSEG_RST = 9'd256;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_ENQ   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DEQ   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FLUSH = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SEG = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SHORT  = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_EQ_CHECK,
      ST_EQ_TAKE,
      ST_EQ_LINK,
      ST_EQ_WRITE,
      ST_EQ_END,
      ST_ABORT,
      ST_FLUSH,
      ST_DQ_CHECK,
      ST_DQ_READ,
      ST_DQ_STEP,
      ST_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LATCH,
      OP_OPEN,
      OP_SET_FAIL,
      OP_TAKE_RD,
      OP_TAKE,
      OP_LINK_PREV,
      OP_WRITE,
      OP_FAIL_END,
      OP_COMMIT,
      OP_ABORT,
      OP_FLUSH,
      OP_DQ_FAIL,
      OP_DQ_ZERO,
      OP_DQ_INIT,
      OP_DQ_READ,
      OP_DQ_STEP
   } op_type;

   typedef struct packed {
      logic [TYPE_W-1:0] rtype;
      logic              last;
      logic              bfail;
      logic              need_seg;
      logic              can_take;
      logic              deq_fail;
      logic              deq_zero;
      logic              res_last;
      logic              init_done;
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/core/swq_if.sv
// Handshake channels of the segmented word queue.
`default_nettype none
interface swq_req_if import swq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [DATA_W-1:0] data_word;
   logic              last_word;
   logic [LEN_W-1:0]  deq_len;
   modport source(output valid, req_type, data_word, last_word, deq_len, input ready);
   modport sink(input valid, req_type, data_word, last_word, deq_len, output ready);
endinterface

interface swq_rsp_if import swq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_word;
   logic [STAT_W-1:0] status;
   logic              word_valid;
   logic              last_result;
   modport source(output valid, out_word, status, word_valid, last_result, input ready);
   modport sink(input valid, out_word, status, word_valid, last_result, output ready);
endinterface

interface swq_csr_if import swq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MAXSEG_W-1:0] max_segments;
   modport source(output valid, max_segments, input ready);
   modport sink(input valid, max_segments, output ready);
endinterface
`default_nettype wire

### rtl/core/swq_ctrl.sv
// Sequencer for the segmented word queue: one item at a time.
`default_nettype none
module swq_ctrl import swq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output op_type           op
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT: begin
            op = OP_INIT;
            if (stat.init_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.rtype == REQ_ENQ) begin
               op       = OP_OPEN;
               state_in = ST_EQ_CHECK;
            end else if (stat.rtype == REQ_DEQ || stat.rtype == REQ_FLUSH) begin
               state_in = ST_ABORT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EQ_CHECK: begin
            if (stat.bfail) begin
               state_in = ST_EQ_END;
            end else if (!stat.need_seg) begin
               state_in = ST_EQ_WRITE;
            end else if (stat.can_take) begin
               op       = OP_TAKE_RD;
               state_in = ST_EQ_TAKE;
            end else begin
               op       = OP_SET_FAIL;
               state_in = ST_EQ_END;
            end
         end
         ST_EQ_TAKE: begin
            op       = OP_TAKE;
            state_in = ST_EQ_LINK;
         end
         ST_EQ_LINK: begin
            op       = OP_LINK_PREV;
            state_in = ST_EQ_WRITE;
         end
         ST_EQ_WRITE: begin
            op       = OP_WRITE;
            state_in = ST_EQ_END;
         end
         ST_EQ_END: begin
            if (!stat.last) begin
               state_in = ST_IDLE;
            end else begin
               op       = stat.bfail ? OP_FAIL_END : OP_COMMIT;
               state_in = ST_RESP;
            end
         end
         ST_ABORT: begin
            op       = OP_ABORT;
            state_in = (stat.rtype == REQ_DEQ) ? ST_DQ_CHECK : ST_FLUSH;
         end
         ST_FLUSH: begin
            op       = OP_FLUSH;
            state_in = ST_RESP;
         end
         ST_DQ_CHECK: begin
            if (stat.deq_fail) begin
               op       = OP_DQ_FAIL;
               state_in = ST_RESP;
            end else if (stat.deq_zero) begin
               op       = OP_DQ_ZERO;
               state_in = ST_RESP;
            end else begin
               op       = OP_DQ_INIT;
               state_in = ST_DQ_READ;
            end
         end
         ST_DQ_READ: begin
            op       = OP_DQ_READ;
            state_in = ST_DQ_STEP;
         end
         ST_DQ_STEP: begin
            op       = OP_DQ_STEP;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = stat.res_last ? ST_IDLE : ST_DQ_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/swq_dp.sv
// Datapath of the segmented word queue: pointers, counters, link and word memories.
`default_nettype none
module swq_dp import swq_pkg::*; #(
   parameter int SEG_WORDS = 64,
   parameter int NUM_SEGS  = 256,
   parameter int MAX_DEQ   = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire op_type              op,
   output dp_stat_type              stat,
   input  wire logic [TYPE_W-1:0]   in_type,
   input  wire logic [DATA_W-1:0]   in_data,
   input  wire logic                in_last,
   input  wire logic [LEN_W-1:0]    in_len,
   input  wire logic                csr_we,
   input  wire logic [MAXSEG_W-1:0] csr_data,
   output logic [DATA_W-1:0]        res_word,
   output logic [STAT_W-1:0]        res_stat,
   output logic                     res_valid,
   output logic                     res_last
);

   localparam int IW = $clog2(NUM_SEGS);
   localparam int SW = $clog2(NUM_SEGS + 1);
   localparam int OW = $clog2(SEG_WORDS);
   localparam int FW = $clog2(SEG_WORDS + 1);
   localparam int AW = $clog2(NUM_SEGS * SEG_WORDS);
   localparam int QW = $clog2(NUM_SEGS * SEG_WORDS + 1);
   localparam logic [SW-1:0] NIL = SW'(NUM_SEGS);

   // memories
   logic [SW-1:0]     link_mem [NUM_SEGS];
   logic [DATA_W-1:0] word_mem [NUM_SEGS * SEG_WORDS];

   logic              link_we;
   logic [IW-1:0]     link_wa, link_ra;
   logic [SW-1:0]     link_wd, link_rd_ff;
   logic              word_we;
   logic [AW-1:0]     word_wa, word_ra;
   logic [DATA_W-1:0] word_rd_ff;

   // latched request
   logic [TYPE_W-1:0] r_type_ff, r_type_in;
   logic [DATA_W-1:0] r_data_ff, r_data_in;
   logic              r_last_ff, r_last_in;
   logic [LEN_W-1:0]  r_len_ff, r_len_in;

   // queue and burst state
   logic [SW-1:0]       free_head_ff, free_head_in;
   logic [SW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [OW-1:0]       off_ff, off_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [QW-1:0]       qlen_ff, qlen_in;
   logic [SW-1:0]       used_ff, used_in;
   logic                bopen_ff, bopen_in, bfail_ff, bfail_in;
   logic [SW-1:0]       bfirst_ff, bfirst_in, btail_ff, btail_in, bnew_ff, bnew_in;
   logic [QW-1:0]       bwords_ff, bwords_in;
   logic [FW-1:0]       bfill_ff, bfill_in;
   logic [SW-1:0]       prev_ff, prev_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [MAXSEG_W-1:0] maxseg_ff, maxseg_in;
   logic [IW-1:0]       init_ff, init_in;

   // result register
   logic [DATA_W-1:0] res_word_ff, res_word_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic              res_valid_ff, res_valid_in, res_last_ff, res_last_in;

   logic [FW-1:0] off_next;

   function automatic logic seg_ok(input logic [SW-1:0] s);
      return s < NIL;
   endfunction

   // memory ports
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (word_we) word_mem[word_wa] <= r_data_ff;
      word_rd_ff <= word_mem[word_ra];
   end

   assign off_next = FW'(off_ff) + FW'(1);

   // next state of the datapath per command
   always_comb begin
      r_type_in    = r_type_ff;
      r_data_in    = r_data_ff;
      r_last_in    = r_last_ff;
      r_len_in     = r_len_ff;
      free_head_in = free_head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      off_in       = off_ff;
      fill_in      = fill_ff;
      qlen_in      = qlen_ff;
      used_in      = used_ff;
      bopen_in     = bopen_ff;
      bfail_in     = bfail_ff;
      bfirst_in    = bfirst_ff;
      btail_in     = btail_ff;
      bnew_in      = bnew_ff;
      bwords_in    = bwords_ff;
      bfill_in     = bfill_ff;
      prev_in      = prev_ff;
      k_in         = k_ff;
      maxseg_in    = csr_we ? csr_data : maxseg_ff;
      init_in      = init_ff;
      res_word_in  = res_word_ff;
      res_stat_in  = res_stat_ff;
      res_valid_in = res_valid_ff;
      res_last_in  = res_last_ff;
      link_we      = 1'b0;
      link_wa      = free_head_ff[IW-1:0];
      link_wd      = free_head_ff;
      link_ra      = free_head_ff[IW-1:0];
      word_we      = 1'b0;
      word_wa      = AW'(btail_ff[IW-1:0]) * AW'(SEG_WORDS) + AW'(bfill_ff);
      word_ra      = AW'(head_ff[IW-1:0]) * AW'(SEG_WORDS) + AW'(off_ff);

      case (op)
         OP_INIT: begin
            link_we = 1'b1;
            link_wa = init_ff;
            link_wd = SW'(init_ff) + SW'(1);
            init_in = init_ff + IW'(1);
         end
         OP_LATCH: begin
            r_type_in = in_type;
            r_data_in = in_data;
            r_last_in = in_last;
            r_len_in  = in_len;
         end
         OP_OPEN: begin
            if (!bopen_ff) begin
               bopen_in  = 1'b1;
               bfail_in  = 1'b0;
               bfirst_in = NIL;
               bwords_in = '0;
               bnew_in   = '0;
               btail_in  = tail_ff;
               bfill_in  = fill_ff;
            end
         end
         OP_SET_FAIL: begin
            bfail_in = 1'b1;
         end
         OP_TAKE_RD: begin
            link_ra = free_head_ff[IW-1:0];
         end
         OP_TAKE: begin
            // pop the free list; the popped segment ends the chain
            free_head_in = link_rd_ff;
            link_we      = 1'b1;
            link_wa      = free_head_ff[IW-1:0];
            link_wd      = NIL;
            used_in      = used_ff + SW'(1);
            bnew_in      = bnew_ff + SW'(1);
            prev_in      = btail_ff;
            if (!seg_ok(bfirst_ff)) bfirst_in = free_head_ff;
            btail_in     = free_head_ff;
            bfill_in     = '0;
         end
         OP_LINK_PREV: begin
            if (seg_ok(prev_ff)) begin
               link_we = 1'b1;
               link_wa = prev_ff[IW-1:0];
               link_wd = btail_ff;
            end
         end
         OP_WRITE: begin
            word_we   = 1'b1;
            bfill_in  = bfill_ff + FW'(1);
            bwords_in = bwords_ff + QW'(1);
         end
         OP_COMMIT: begin
            if (!seg_ok(head_ff)) begin
               head_in = bfirst_ff;
               off_in  = '0;
            end
            tail_in   = btail_ff;
            fill_in   = bfill_ff;
            qlen_in   = qlen_ff + bwords_ff;
            bopen_in  = 1'b0;
            bfail_in  = 1'b0;
            bfirst_in = NIL;
            bwords_in = '0;
            btail_in  = NIL;
            bfill_in  = '0;
            bnew_in   = '0;
            res_word_in  = '0;
            res_stat_in  = STAT_OK;
            res_valid_in = 1'b0;
            res_last_in  = 1'b1;
         end
         OP_FAIL_END, OP_ABORT: begin
            // splice the burst's new segments back onto the free list
            if (bopen_ff && seg_ok(bfirst_ff)) begin
               link_we      = 1'b1;
               link_wa      = btail_ff[IW-1:0];
               link_wd      = free_head_ff;
               free_head_in = bfirst_ff;
               used_in      = used_ff - bnew_ff;
            end
            bopen_in  = 1'b0;
            bfail_in  = 1'b0;
            bfirst_in = NIL;
            bwords_in = '0;
            btail_in  = NIL;
            bfill_in  = '0;
            bnew_in   = '0;
            if (op == OP_FAIL_END) begin
               res_word_in  = '0;
               res_stat_in  = STAT_NO_SEG;
               res_valid_in = 1'b0;
               res_last_in  = 1'b1;
            end
         end
         OP_FLUSH: begin
            if (seg_ok(head_ff)) begin
               link_we      = 1'b1;
               link_wa      = tail_ff[IW-1:0];
               link_wd      = free_head_ff;
               free_head_in = head_ff;
               used_in      = '0;
            end
            head_in      = NIL;
            tail_in      = NIL;
            off_in       = '0;
            fill_in      = '0;
            qlen_in      = '0;
            res_word_in  = '0;
            res_stat_in  = STAT_OK;
            res_valid_in = 1'b0;
            res_last_in  = 1'b1;
         end
         OP_DQ_FAIL, OP_DQ_ZERO: begin
            res_word_in  = '0;
            res_stat_in  = (op == OP_DQ_FAIL) ? STAT_SHORT : STAT_OK;
            res_valid_in = 1'b0;
            res_last_in  = 1'b1;
         end
         OP_DQ_INIT: begin
            k_in = '0;
         end
         OP_DQ_READ: begin
            link_ra = head_ff[IW-1:0];
         end
         OP_DQ_STEP: begin
            res_word_in  = word_rd_ff;
            res_stat_in  = STAT_OK;
            res_valid_in = 1'b1;
            res_last_in  = (k_ff + LEN_W'(1)) == r_len_ff;
            k_in         = k_ff + LEN_W'(1);
            qlen_in      = qlen_ff - QW'(1);
            off_in       = off_next[OW-1:0];
            // a drained segment goes back to the free list
            if ((head_ff == tail_ff && off_next >= fill_ff) ||
                off_next >= FW'(SEG_WORDS)) begin
               link_we      = 1'b1;
               link_wa      = head_ff[IW-1:0];
               link_wd      = free_head_ff;
               free_head_in = head_ff;
               used_in      = used_ff - SW'(1);
               off_in       = '0;
               if (head_ff == tail_ff && off_next >= fill_ff) begin
                  head_in = NIL;
                  tail_in = NIL;
                  fill_in = '0;
               end else begin
                  head_in = link_rd_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         off_ff       <= '0;
         fill_ff      <= '0;
         qlen_ff      <= '0;
         used_ff      <= '0;
         bopen_ff     <= 1'b0;
         bfail_ff     <= 1'b0;
         bfirst_ff    <= NIL;
         btail_ff     <= NIL;
         bnew_ff      <= '0;
         bwords_ff    <= '0;
         bfill_ff     <= '0;
         k_ff         <= '0;
         maxseg_ff    <= MAXSEG_RST;
         init_ff      <= '0;
      end else begin
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         off_ff       <= off_in;
         fill_ff      <= fill_in;
         qlen_ff      <= qlen_in;
         used_ff      <= used_in;
         bopen_ff     <= bopen_in;
         bfail_ff     <= bfail_in;
         bfirst_ff    <= bfirst_in;
         btail_ff     <= btail_in;
         bnew_ff      <= bnew_in;
         bwords_ff    <= bwords_in;
         bfill_ff     <= bfill_in;
         k_ff         <= k_in;
         maxseg_ff    <= maxseg_in;
         init_ff      <= init_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_type_ff    <= r_type_in;
      r_data_ff    <= r_data_in;
      r_last_ff    <= r_last_in;
      r_len_ff     <= r_len_in;
      prev_ff      <= prev_in;
      res_word_ff  <= res_word_in;
      res_stat_ff  <= res_stat_in;
      res_valid_ff <= res_valid_in;
      res_last_ff  <= res_last_in;
   end

   // status toward the sequencer
   always_comb begin
      stat.rtype     = r_type_ff;
      stat.last      = r_last_ff;
      stat.bfail     = bfail_ff;
      stat.need_seg  = !seg_ok(btail_ff) || bfill_ff >= FW'(SEG_WORDS);
      stat.can_take  = seg_ok(free_head_ff) && (32'(used_ff) < 32'(maxseg_ff));
      stat.deq_fail  = !seg_ok(head_ff) || (32'(r_len_ff) > 32'(qlen_ff)) ||
                       (32'(r_len_ff) > 32'(MAX_DEQ));
      stat.deq_zero  = r_len_ff == '0;
      stat.res_last  = res_last_ff;
      stat.init_done = init_ff == IW'(NUM_SEGS - 1);
   end

   assign res_word  = res_word_ff;
   assign res_stat  = res_stat_ff;
   assign res_valid = res_valid_ff;
   assign res_last  = res_last_ff;

endmodule
`default_nettype wire

### rtl/core/segmented_word_queue_core.sv
// Top level of the segmented word queue.
`default_nettype none
// A FIFO of 32-bit words held in linked segments of SEG_WORDS words taken from a
// free list of NUM_SEGS segments. Enqueue bursts (one word per item, last_word on
// the final one) commit all-or-nothing and answer one status item; a dequeue of N
// words answers N word items or one status item; a flush answers one status item.
// After reset the link memory is initialized over all NUM_SEGS segments, during
// which no item is accepted. The block handles one item at a time under a single
// sequencer: an enqueue word passes dispatch, check, write and end states, with
// take and link before the write when it opens a new segment (a read and up to
// two link memory writes) and the result state on the final word; a flush passes
// dispatch, abort, flush and result; a dequeue passes dispatch, abort and check,
// then per word read (registered read), step (pointer update, output), result.
module segmented_word_queue_core import swq_pkg::*; #(
   parameter int SEG_WORDS = 64,
   parameter int NUM_SEGS  = 256,
   parameter int MAX_DEQ   = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   swq_req_if.sink   req_ch,
   swq_rsp_if.source rsp_ch,
   swq_csr_if.sink   csr_ch
);

   op_type      op;
   dp_stat_type stat;

   assign csr_ch.ready = 1'b1;

   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .op        (op)
   );

   swq_dp #(
      .SEG_WORDS (SEG_WORDS),
      .NUM_SEGS  (NUM_SEGS),
      .MAX_DEQ   (MAX_DEQ)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .stat      (stat),
      .in_type   (req_ch.req_type),
      .in_data   (req_ch.data_word),
      .in_last   (req_ch.last_word),
      .in_len    (req_ch.deq_len),
      .csr_we    (csr_ch.valid),
      .csr_data  (csr_ch.max_segments),
      .res_word  (rsp_ch.out_word),
      .res_stat  (rsp_ch.status),
      .res_valid (rsp_ch.word_valid),
      .res_last  (rsp_ch.last_result)
   );

   // no new item is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("item accepted while a result is pending");

   // word items always carry ok status
   a_word_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.word_valid |-> rsp_ch.status == STAT_OK)
      else $error("word item with error status");

   // status-only items end their request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.word_valid |-> rsp_ch.last_result)
      else $error("status item not marked last");

endmodule
`default_nettype wire

### bench/tb_segmented_word_queue_core.sv
// Testbench for segmented_word_queue_core: directed and random requests checked by a scoreboard.
`default_nettype none
module tb_segmented_word_queue_core;
   import swq_pkg::*;

   localparam int SEG_WORDS = 64;
   localparam int NUM_SEGS  = 256;
   localparam int MAX_DEQ   = 64;
   localparam int SEG_NIL   = NUM_SEGS;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET = 170;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [DATA_W-1:0] out_word;
      logic [STAT_W-1:0] status;
      logic              word_valid;
      logic              last_result;
   } queue_result_type;

   // Predicts the queue's answers and holds them until they come out
   class word_queue_scoreboard;
      int link[NUM_SEGS];
      logic [DATA_W-1:0] store[NUM_SEGS*SEG_WORDS];
      int free_head, head_seg, head_off, tail_seg, tail_fill, queue_len, segs_used;
      int seg_limit;
      bit burst_open, burst_failed;
      int burst_first, burst_words, burst_tail, burst_fill;
      queue_result_type pending[$];
      int errors;

      function new();
         for (int i = 0; i < NUM_SEGS; i++) link[i] = i + 1;
         free_head = 0;
         head_seg = SEG_NIL;
         tail_seg = SEG_NIL;
         head_off = 0;
         tail_fill = 0;
         queue_len = 0;
         segs_used = 0;
         seg_limit = int'(MAXSEG_RST);
         errors = 0;
         clear_burst();
      endfunction

      function void clear_burst();
         burst_open = 0;
         burst_failed = 0;
         burst_first = SEG_NIL;
         burst_words = 0;
         burst_tail = SEG_NIL;
         burst_fill = 0;
      endfunction

      function bit take_seg(output int s);
         s = SEG_NIL;
         if (free_head >= NUM_SEGS || segs_used >= seg_limit) return 0;
         s = free_head;
         free_head = link[s];
         link[s] = SEG_NIL;
         segs_used++;
         return 1;
      endfunction

      function void give_seg(int s);
         if (s >= NUM_SEGS) return;
         link[s] = free_head;
         free_head = s;
         if (segs_used > 0) segs_used--;
      endfunction

      // release a chain, first through stop inclusive
      function void give_chain(int first, int stop);
         int s, nxt, n;
         s = first;
         n = 0;
         while (s < NUM_SEGS && n < NUM_SEGS) begin
            nxt = link[s];
            give_seg(s);
            if (s == stop) break;
            s = nxt;
            n++;
         end
      endfunction

      function void abort_burst();
         if (burst_open && burst_first < NUM_SEGS) give_chain(burst_first, burst_tail);
         clear_burst();
      endfunction

      function void push(logic [DATA_W-1:0] w, logic [STAT_W-1:0] st, bit wv, bit lr);
         queue_result_type r;
         r.out_word = w;
         r.status = st;
         r.word_valid = wv;
         r.last_result = lr;
         pending.push_back(r);
      endfunction

      function void enqueue_word(logic [DATA_W-1:0] data, bit last);
         int ns;
         if (!burst_open) begin
            clear_burst();
            burst_open = 1;
            burst_tail = tail_seg;
            burst_fill = tail_fill;
         end
         if (!burst_failed) begin
            if (burst_tail >= NUM_SEGS || burst_fill >= SEG_WORDS) begin
               if (!take_seg(ns)) begin
                  burst_failed = 1;
               end else begin
                  if (burst_tail < NUM_SEGS) link[burst_tail] = ns;
                  if (burst_first >= NUM_SEGS) burst_first = ns;
                  burst_tail = ns;
                  burst_fill = 0;
               end
            end
            if (!burst_failed) begin
               store[burst_tail*SEG_WORDS + burst_fill] = data;
               burst_fill++;
               burst_words++;
            end
         end
         if (!last) return;
         if (burst_failed) begin
            abort_burst();
            push('0, STAT_NO_SEG, 0, 1);
            return;
         end
         if (head_seg >= NUM_SEGS) begin
            head_seg = burst_first;
            head_off = 0;
         end
         tail_seg = burst_tail;
         tail_fill = burst_fill;
         queue_len += burst_words;
         clear_burst();
         push('0, STAT_OK, 0, 1);
      endfunction

      function void dequeue_words(int n);
         int s, nxt;
         logic [DATA_W-1:0] w;
         if (head_seg >= NUM_SEGS || n > queue_len || n > MAX_DEQ) begin
            push('0, STAT_SHORT, 0, 1);
            return;
         end
         if (n == 0) begin
            push('0, STAT_OK, 0, 1);
            return;
         end
         for (int k = 0; k < n; k++) begin
            s = head_seg;
            w = '0;
            if (s < NUM_SEGS && head_off < SEG_WORDS) w = store[s*SEG_WORDS + head_off];
            push(w, STAT_OK, 1, k + 1 == n);
            head_off++;
            if (queue_len > 0) queue_len--;
            if (s == tail_seg && head_off >= tail_fill) begin
               give_seg(s);
               head_seg = SEG_NIL;
               tail_seg = SEG_NIL;
               head_off = 0;
               tail_fill = 0;
            end else if (head_off >= SEG_WORDS) begin
               nxt = (s < NUM_SEGS) ? link[s] : SEG_NIL;
               give_seg(s);
               head_seg = nxt;
               head_off = 0;
            end
         end
      endfunction

      function void note_request(logic [TYPE_W-1:0] rt, logic [DATA_W-1:0] data, bit last,
                                 logic [LEN_W-1:0] len);
         case (rt)
            REQ_ENQ: enqueue_word(data, last);
            REQ_DEQ: begin
               abort_burst();
               dequeue_words(int'(len));
            end
            REQ_FLUSH: begin
               abort_burst();
               if (head_seg < NUM_SEGS) give_chain(head_seg, tail_seg);
               head_seg = SEG_NIL;
               tail_seg = SEG_NIL;
               head_off = 0;
               tail_fill = 0;
               queue_len = 0;
               push('0, STAT_OK, 0, 1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(queue_result_type got);
         queue_result_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result: out_word %h status %0d", got.out_word, got.status);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.out_word !== exp.out_word) begin
            $error("out_word: expected %h, got %h", exp.out_word, got.out_word);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.word_valid !== exp.word_valid) begin
            $error("word_valid: expected %0d, got %0d", exp.word_valid, got.word_valid);
            errors++;
         end
         if (got.last_result !== exp.last_result) begin
            $error("last_result: expected %0d, got %0d", exp.last_result, got.last_result);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int items_sent = 0;
   word_queue_scoreboard sb;

   swq_req_if req_ch();
   swq_rsp_if rsp_ch();
   swq_csr_if csr_ch();

   segmented_word_queue_core #(
      .SEG_WORDS(SEG_WORDS),
      .NUM_SEGS(NUM_SEGS),
      .MAX_DEQ(MAX_DEQ)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #10 clock = ~clock;

   initial begin
      sb = new();
      req_ch.valid = 0;
      req_ch.req_type = REQ_ENQ;
      req_ch.data_word = '0;
      req_ch.last_word = 0;
      req_ch.deq_len = '0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.max_segments = MAXSEG_RST;
   end

   // result side: random stalls, changed at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // result check and stall watchdog
   always @(posedge clock) begin
      queue_result_type r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         r.out_word = rsp_ch.out_word;
         r.status = rsp_ch.status;
         r.word_valid = rsp_ch.word_valid;
         r.last_result = rsp_ch.last_result;
         sb.check_result(r);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("segmented_word_queue_core verification failed");
         $finish;
      end
   end

   // one item on the request channel, noted once accepted
   task automatic send_req(logic [TYPE_W-1:0] rt, logic [DATA_W-1:0] data, bit last,
                           logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_ch.valid = 1;
      req_ch.req_type = rt;
      req_ch.data_word = data;
      req_ch.last_word = last;
      req_ch.deq_len = len;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(rt, data, last, len);
      if (rt != REQ_UNUSED) items_sent++;
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   // burst of n words; closed with last_word unless left open
   task automatic enqueue_burst(int n, bit close_it = 1);
      for (int i = 0; i < n; i++)
         send_req(REQ_ENQ, $urandom(), close_it && (i == n - 1),
                  LEN_W'($urandom_range(127)));
   endtask

   task automatic dequeue(int n);
      send_req(REQ_DEQ, $urandom(), 1'($urandom_range(1)), LEN_W'(n));
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // segment limit write, only once the queue has gone quiet
   task automatic write_limit(int v);
      drain();
      csr_ch.valid = 1;
      csr_ch.max_segments = MAXSEG_W'(v);
      do @(posedge clock); while (!csr_ch.ready);
      sb.seg_limit = v;
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   initial begin
      int mode, pick, n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, every request type, abort and failure cases
      send_req(REQ_ENQ, 32'h0000_0000, 1, 7'd0);
      send_req(REQ_ENQ, 32'hFFFF_FFFF, 0, 7'd127);
      send_req(REQ_ENQ, 32'hA5A5_5A5A, 1, 7'd64);
      dequeue(0);
      dequeue(2);
      dequeue(5);
      dequeue(127);
      send_req(REQ_UNUSED, 32'hDEAD_BEEF, 1, 7'd3);
      dequeue(65);
      send_req(REQ_FLUSH, '0, 0, 7'd0);
      dequeue(0);
      enqueue_burst(3, 0);
      dequeue(1);
      enqueue_burst(2, 0);
      send_req(REQ_FLUSH, '1, 1, 7'd127);
      enqueue_burst(66);
      dequeue(64);
      dequeue(2);
      write_limit(1);
      enqueue_burst(65);
      enqueue_burst(3);
      dequeue(3);
      write_limit(256);

      // random phases over idle modes and segment limits
      mode = 0;
      while (mode < 4 || items_sent < ITEM_TARGET) begin
         case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (mode % 5)
            0: write_limit(1);
            1: write_limit(256);
            2: write_limit(2);
            3: write_limit($urandom_range(3, 255));
            default: write_limit(3);
         endcase
         repeat (2) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               n = ($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 6);
               enqueue_burst(n);
            end else if (pick < 58) begin
               enqueue_burst($urandom_range(1, 4), 0);
            end else if (pick < 85) begin
               n = sb.queue_len > MAX_DEQ ? MAX_DEQ : sb.queue_len;
               if ($urandom_range(5) == 0) n = $urandom_range(127);
               else n = $urandom_range(n);
               dequeue(n);
            end else if (pick < 95) begin
               send_req(REQ_FLUSH, $urandom(), 1'($urandom_range(1)),
                        LEN_W'($urandom_range(127)));
            end else begin
               send_req(REQ_UNUSED, $urandom(), 1'($urandom_range(1)),
                        LEN_W'($urandom_range(127)));
            end
         end
         mode++;
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (sb.pending.size() != 0) begin
         $error("%0d expected results never arrived", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("segmented_word_queue_core verification clean");
      else
         $display("segmented_word_queue_core verification failed");
      $finish;
   end
endmodule
`default_nettype wire
